@@ rtl/ptl_pkg.sv @@
`timescale 1ns / 1ps

package ptl_pkg;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_e;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_GREEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_YELLOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RED    = 2'd2;

  localparam logic [7:0] GREEN_RST  = 8'd10;
  localparam logic [7:0] YELLOW_RST = 8'd20;
  localparam logic [7:0] RED_RST    = 8'd20;

  // lamp bit positions
  localparam int unsigned L_CG = 0;
  localparam int unsigned L_CY = 1;
  localparam int unsigned L_CR = 2;
  localparam int unsigned L_WG = 3;
  localparam int unsigned L_WY = 4;
  localparam int unsigned L_WR = 5;

  typedef struct packed {
    logic [7:0] green_half_seconds;
    logic [7:0] yellow_ticks;
    logic [7:0] red_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [8:0] tick;
    logic       mode;       // crossing mode
    logic       ny_par;     // normal yellow parity
    logic       cy_par;     // crossing yellow parity
    logic       cr_par;     // crossing red parity
    logic       pend_green; // return to green owed after the coming red
    logic       red_cross;  // running red pass belongs to crossing mode
    logic [5:0] lamps;
  } st_t;

  typedef struct packed {
    logic       car_green;
    logic       car_yellow;
    logic       car_red;
    logic       walk_green;
    logic       walk_yellow;
    logic       walk_red;
    logic       ped_mode;
    logic [1:0] phase_now;
  } res_t;

  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic st_t green_lamps(st_t s);
    st_t r;
    r = s;
    r.lamps[L_CG] = 1'b1;
    r.lamps[L_CR] = 1'b0;
    r.lamps[L_CY] = 1'b0;
    return r;
  endfunction

  function automatic st_t enter_green(st_t s);
    st_t r;
    r = green_lamps(s);
    r.phase      = PH_GREEN;
    r.tick       = '0;
    r.pend_green = 1'b0;
    return r;
  endfunction

  function automatic st_t enter_cross_yellow(st_t s);
    st_t r;
    r = s;
    r.phase = PH_YELLOW;
    r.tick  = '0;
    r.lamps[L_WR] = ~s.cy_par;
    r.lamps[L_CY] = 1'b0;
    return r;
  endfunction

  function automatic st_t enter_yellow(st_t s);
    st_t r;
    r = s;
    r.phase = PH_YELLOW;
    r.tick  = '0;
    r.lamps[L_CG] = 1'b0;
    r.lamps[L_CR] = 1'b0;
    if (!s.mode) begin
      r.lamps[L_WG] = 1'b0;
      r.lamps[L_WR] = 1'b0;
    end else begin
      r = enter_cross_yellow(r);
    end
    return r;
  endfunction

  function automatic st_t enter_red(st_t s);
    st_t r;
    r = s;
    r.phase = PH_RED;
    r.tick  = '0;
    r.lamps[L_CY] = 1'b0;
    r.lamps[L_WY] = 1'b0;
    if (s.mode) begin
      r.red_cross = 1'b1;
      r.cr_par    = ~s.cr_par;
      if (!s.cr_par) begin
        r.lamps[L_WR] = 1'b0;
        r.lamps[L_CR] = 1'b1;
        r.lamps[L_WG] = 1'b1;
      end else begin
        // second crossing red pass goes straight back to green
        r.lamps[L_WG] = 1'b0;
        r.lamps[L_WR] = 1'b1;
        r.mode        = 1'b0;
        r = enter_green(r);
      end
    end else begin
      r.red_cross   = 1'b0;
      r.lamps[L_CR] = 1'b1;
      r.lamps[L_WG] = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/ptl_if.sv @@
`timescale 1ns / 1ps

interface ptl_in_if;
  logic valid;
  logic ready;
  logic request;

  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

interface ptl_out_if;
  logic       valid;
  logic       ready;
  logic       car_green;
  logic       car_yellow;
  logic       car_red;
  logic       walk_green;
  logic       walk_yellow;
  logic       walk_red;
  logic       ped_mode;
  logic [1:0] phase_now;

  modport source (
    output valid, output car_green, output car_yellow, output car_red,
    output walk_green, output walk_yellow, output walk_red,
    output ped_mode, output phase_now, input ready
  );
  modport sink (
    input valid, input car_green, input car_yellow, input car_red,
    input walk_green, input walk_yellow, input walk_red,
    input ped_mode, input phase_now, output ready
  );
endinterface

@@ rtl/ptl_step.sv @@
`timescale 1ns / 1ps

module ptl_step
  import ptl_pkg::*;
(
  input  st_t  st_i,
  input  logic request_i,
  input  cfg_t cfg_i,
  output st_t  st_o,
  output res_t res_o
);

  logic [7:0] g_len;
  logic [7:0] y_len;
  logic [7:0] r_len;

  assign g_len = at_least_one(cfg_i.green_half_seconds);
  assign y_len = at_least_one(cfg_i.yellow_ticks);
  assign r_len = at_least_one(cfg_i.red_ticks);

  // next state for one tick
  always_comb begin
    st_t  s;
    logic mode_before;
    logic y_done;
    logic to_red;

    s           = st_i;
    mode_before = st_i.mode;
    y_done      = 1'b0;
    to_red      = 1'b0;
    if (request_i) s.mode = 1'b1;

    unique case (s.phase)
      PH_GREEN: begin
        s      = green_lamps(s);
        s.tick = s.tick + 9'd1;
        // request and length checked every second tick
        if (!s.tick[0] && (s.mode || (s.tick[8:1] >= g_len))) begin
          if (s.mode) s.lamps[L_WR] = 1'b1;
          s = enter_yellow(s);
        end
      end
      PH_YELLOW: begin
        s      = st_i;
        s.mode = st_i.mode | request_i;
        s.tick = st_i.tick + 9'd1;
        y_done = (s.tick >= {1'b0, y_len});
        if (!mode_before) begin
          s.lamps[L_CY] = ~s.lamps[L_CY];
          if (s.mode || y_done) begin
            if (y_done) begin
              if (!s.ny_par) to_red = 1'b1;
              else s.pend_green = 1'b1;
              s.ny_par = ~s.ny_par;
            end
            if (s.mode) s = enter_cross_yellow(s);
            else if (to_red) s = enter_red(s);
            else s = enter_green(s);
          end
        end else begin
          s.lamps[L_CY] = ~s.lamps[L_CY];
          s.lamps[L_WY] = ~s.lamps[L_WY];
          if (y_done) begin
            s.cy_par = ~s.cy_par;
            s = enter_red(s);
          end
        end
      end
      PH_RED: begin
        s.tick = s.tick + 9'd1;
        if (s.tick >= {1'b0, r_len}) begin
          // a request during normal red is dropped at its end
          if (s.red_cross) s.lamps[L_CR] = 1'b0;
          else s.mode = 1'b0;
          if (s.pend_green) s = enter_green(s);
          else s = enter_yellow(s);
        end
      end
      default: begin
        s = enter_green(s);
      end
    endcase

    st_o = s;
  end

  // result fields follow the state after the tick
  always_comb begin
    res_o.car_green   = st_o.lamps[L_CG];
    res_o.car_yellow  = st_o.lamps[L_CY];
    res_o.car_red     = st_o.lamps[L_CR];
    res_o.walk_green  = st_o.lamps[L_WG];
    res_o.walk_yellow = st_o.lamps[L_WY];
    res_o.walk_red    = st_o.lamps[L_WR];
    res_o.ped_mode    = st_o.mode;
    res_o.phase_now   = st_o.phase;
  end

endmodule

@@ rtl/pedestrian_traffic_light_fsm.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Per item
// in_if     in   request                                   one tick
// out_if    out  six lamps, ped_mode, phase_now            one result per tick
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i         register write
//
// One tick is taken per cycle while in_if.ready is high; result goes to the
// output register. The tick state and the result register load together.
// in_if.ready is high while the output register is empty or being taken,
// so a stalled sink holds one result and stops further ticks.
// Reset loads the register defaults, phase green and all lamps off.

module pedestrian_traffic_light_fsm
  import ptl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  ptl_in_if.sink               in_if,
  ptl_out_if.source            out_if
);

  cfg_t cfg_q;
  st_t  st_q;
  st_t  st_d;
  res_t res_d;
  res_t out_q;
  logic out_valid_q;
  logic in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_half_seconds <= GREEN_RST;
      cfg_q.yellow_ticks       <= YELLOW_RST;
      cfg_q.red_ticks          <= RED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GREEN:  cfg_q.green_half_seconds <= cfg_data_i;
        REG_YELLOW: cfg_q.yellow_ticks       <= cfg_data_i;
        REG_RED:    cfg_q.red_ticks          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  ptl_step u_step (
    .st_i      (st_q),
    .request_i (in_if.request),
    .cfg_i     (cfg_q),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_GREEN;
      st_q.tick       <= '0;
      st_q.mode       <= 1'b0;
      st_q.ny_par     <= 1'b0;
      st_q.cy_par     <= 1'b0;
      st_q.cr_par     <= 1'b0;
      st_q.pend_green <= 1'b0;
      st_q.red_cross  <= 1'b0;
      st_q.lamps      <= '0;
      out_valid_q     <= 1'b0;
    end else if (in_acc) begin
      st_q        <= st_d;
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= res_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.car_green   = out_q.car_green;
  assign out_if.car_yellow  = out_q.car_yellow;
  assign out_if.car_red     = out_q.car_red;
  assign out_if.walk_green  = out_q.walk_green;
  assign out_if.walk_yellow = out_q.walk_yellow;
  assign out_if.walk_red    = out_q.walk_red;
  assign out_if.ped_mode    = out_q.ped_mode;
  assign out_if.phase_now   = out_q.phase_now;

  a_acc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> $stable(st_q))
    else $error("state advanced while result stalled");

  a_phase_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.phase_now == st_q.phase && out_q.ped_mode == st_q.mode))
    else $error("result out of step with state");

  a_car_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.car_green && out_q.car_red))
    else $error("car green and red lit together");

endmodule
